// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared widths, action codes and pipeline stage types.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int PW        = 2 * WORD_BITS;
    localparam int XW        = PW + FRAC_BITS;

    localparam logic [2:0] ACT_ADD  = 3'd0;
    localparam logic [2:0] ACT_SUB  = 3'd1;
    localparam logic [2:0] ACT_MUL  = 3'd2;
    localparam logic [2:0] ACT_DIV  = 3'd3;
    localparam logic [2:0] ACT_NEG  = 3'd4;
    localparam logic [2:0] ACT_CONJ = 3'd5;

    typedef logic signed [PW:0] t_wide;

    // Information that rides along with an item through the divider cells.
    typedef struct packed {
        logic [2:0] act;
        t_wide      dre;
        t_wide      dim;
        logic       neg_re;
        logic       neg_im;
        logic       ovf_re;
        logic       ovf_im;
        logic       dz;
    } t_side;

    // One stage of the divider chain.
    typedef struct packed {
        logic                 vld;
        t_side                sd;
        logic [PW-1:0]        r_re;
        logic [PW-1:0]        r_im;
        logic [PW-1:0]        d;
        logic [WORD_BITS-1:0] x_re;
        logic [WORD_BITS-1:0] x_im;
        logic [WORD_BITS-1:0] q_re;
        logic [WORD_BITS-1:0] q_im;
    } t_stage;

endpackage

// ===== hdl/cau_if.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit channel interfaces
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface cau_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [2:0]                            action;
    logic signed [cau_pkg::WORD_BITS-1:0] a_re;
    logic signed [cau_pkg::WORD_BITS-1:0] a_im;
    logic signed [cau_pkg::WORD_BITS-1:0] b_re;
    logic signed [cau_pkg::WORD_BITS-1:0] b_im;

    modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cau_pkg::WORD_BITS-1:0] res_re;
    logic signed [cau_pkg::WORD_BITS-1:0] res_im;
    logic                                  div_by_zero;
    logic                                  overflow;

    modport source (output valid, res_re, res_im, div_by_zero, overflow, input ready);
    modport sink   (input valid, res_re, res_im, div_by_zero, overflow, output ready);
endinterface

// ===== hdl/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Products, sums and divider setup in three pipeline stages.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    cau_in_if.sink          i_in,
    output cau_pkg::t_stage o_stage
);

    localparam int W = cau_pkg::WORD_BITS;
    localparam int F = cau_pkg::FRAC_BITS;
    localparam int PW = cau_pkg::PW;
    localparam int XW = cau_pkg::XW;

    function automatic logic signed [PW-1:0] smul(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [PW-1:0] ea;
        logic signed [PW-1:0] eb;
        ea = PW'(a);
        eb = PW'(b);
        return ea * eb;
    endfunction

    function automatic cau_pkg::t_wide ext(input logic signed [W-1:0] a);
        cau_pkg::t_wide e;
        e = cau_pkg::t_wide'(a);
        return e;
    endfunction

    // Stage 1: six products and the direct results.
    logic                 r_v1;
    logic [2:0]           r_act1;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    cau_pkg::t_wide       r_d1re, r_d1im;
    cau_pkg::t_wide       n_d1re, n_d1im;

    always_comb begin
        n_d1re = '0;
        n_d1im = '0;
        case (i_in.action)
            cau_pkg::ACT_ADD: begin
                n_d1re = ext(i_in.a_re) + ext(i_in.b_re);
                n_d1im = ext(i_in.a_im) + ext(i_in.b_im);
            end
            cau_pkg::ACT_SUB: begin
                n_d1re = ext(i_in.a_re) - ext(i_in.b_re);
                n_d1im = ext(i_in.a_im) - ext(i_in.b_im);
            end
            cau_pkg::ACT_NEG: begin
                n_d1re = -ext(i_in.a_re);
                n_d1im = -ext(i_in.a_im);
            end
            cau_pkg::ACT_CONJ: begin
                n_d1re = ext(i_in.a_re);
                n_d1im = -ext(i_in.a_im);
            end
            default: begin
                n_d1re = '0;
                n_d1im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_in.valid;
        end
        if (i_en) begin
            r_act1 <= i_in.action;
            r_p_rr <= smul(i_in.a_re, i_in.b_re);
            r_p_ii <= smul(i_in.a_im, i_in.b_im);
            r_p_ri <= smul(i_in.a_re, i_in.b_im);
            r_p_ir <= smul(i_in.a_im, i_in.b_re);
            r_p_bb <= smul(i_in.b_re, i_in.b_re);
            r_p_cc <= smul(i_in.b_im, i_in.b_im);
            r_d1re <= n_d1re;
            r_d1im <= n_d1im;
        end
    end

    // Stage 2: product sums, dividend numerators and squared magnitude.
    logic           r_v2;
    logic [2:0]     r_act2;
    cau_pkg::t_wide r_d2re, r_d2im, r_nre, r_nim;
    logic [PW-1:0]  r_den;
    cau_pkg::t_wide n_mre, n_mim;

    assign n_mre = (cau_pkg::t_wide'(r_p_rr) - cau_pkg::t_wide'(r_p_ii)) >>> F;
    assign n_mim = (cau_pkg::t_wide'(r_p_ri) + cau_pkg::t_wide'(r_p_ir)) >>> F;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_act2 <= r_act1;
            r_d2re <= (r_act1 == cau_pkg::ACT_MUL) ? n_mre : r_d1re;
            r_d2im <= (r_act1 == cau_pkg::ACT_MUL) ? n_mim : r_d1im;
            r_nre  <= cau_pkg::t_wide'(r_p_rr) + cau_pkg::t_wide'(r_p_ii);
            r_nim  <= cau_pkg::t_wide'(r_p_ir) - cau_pkg::t_wide'(r_p_ri);
            r_den  <= r_p_bb + r_p_cc;
        end
    end

    // Stage 3: magnitudes, range check and the first partial remainder.
    logic [PW-1:0]  n_mag_re, n_mag_im;
    logic [XW-1:0]  n_x_re, n_x_im;
    logic [PW-1:0]  n_r0_re, n_r0_im;
    cau_pkg::t_stage n_s3, r_s3;

    assign n_mag_re = r_nre[PW] ? PW'(-r_nre) : r_nre[PW-1:0];
    assign n_mag_im = r_nim[PW] ? PW'(-r_nim) : r_nim[PW-1:0];
    assign n_x_re   = {n_mag_re, {F{1'b0}}};
    assign n_x_im   = {n_mag_im, {F{1'b0}}};
    assign n_r0_re  = PW'(n_x_re[XW-1:W]);
    assign n_r0_im  = PW'(n_x_im[XW-1:W]);

    always_comb begin
        n_s3           = '0;
        n_s3.vld       = r_v2;
        n_s3.sd.act    = r_act2;
        n_s3.sd.dre    = r_d2re;
        n_s3.sd.dim    = r_d2im;
        n_s3.sd.neg_re = r_nre[PW];
        n_s3.sd.neg_im = r_nim[PW];
        n_s3.sd.ovf_re = (n_r0_re >= r_den);
        n_s3.sd.ovf_im = (n_r0_im >= r_den);
        n_s3.sd.dz     = (r_act2 == cau_pkg::ACT_DIV) && (r_den == '0);
        n_s3.r_re      = n_r0_re;
        n_s3.r_im      = n_r0_im;
        n_s3.d         = r_den;
        n_s3.x_re      = n_x_re[W-1:0];
        n_s3.x_im      = n_x_im[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (i_en) begin
            r_s3.vld <= n_s3.vld;
        end
        if (i_en) begin
            r_s3.sd   <= n_s3.sd;
            r_s3.r_re <= n_s3.r_re;
            r_s3.r_im <= n_s3.r_im;
            r_s3.d    <= n_s3.d;
            r_s3.x_re <= n_s3.x_re;
            r_s3.x_im <= n_s3.x_im;
            r_s3.q_re <= n_s3.q_re;
            r_s3.q_im <= n_s3.q_im;
        end
    end

    assign i_in.ready = i_en;
    assign o_stage    = r_s3;

endmodule

// ===== hdl/cau_cell.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider cell
// One restoring division step for the real and imaginary quotients.
// ----------------------------------------------------------------------------
module cau_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  cau_pkg::t_stage i_stage,
    output cau_pkg::t_stage o_stage
);

    localparam int W = cau_pkg::WORD_BITS;
    localparam int PW = cau_pkg::PW;

    logic [PW:0]     n_t_re, n_t_im;
    logic            n_b_re, n_b_im;
    cau_pkg::t_stage n_stage, r_stage;

    // Shift in the next dividend bit and subtract the divisor where it fits.
    always_comb begin
        n_t_re = {i_stage.r_re, i_stage.x_re[W-1]};
        n_t_im = {i_stage.r_im, i_stage.x_im[W-1]};
        n_b_re = (n_t_re >= {1'b0, i_stage.d});
        n_b_im = (n_t_im >= {1'b0, i_stage.d});
        if (n_b_re) begin
            n_t_re = n_t_re - {1'b0, i_stage.d};
        end
        if (n_b_im) begin
            n_t_im = n_t_im - {1'b0, i_stage.d};
        end
        n_stage      = i_stage;
        n_stage.r_re = n_t_re[PW-1:0];
        n_stage.r_im = n_t_im[PW-1:0];
        n_stage.x_re = {i_stage.x_re[W-2:0], 1'b0};
        n_stage.x_im = {i_stage.x_im[W-2:0], 1'b0};
        n_stage.q_re = {i_stage.q_re[W-2:0], n_b_re};
        n_stage.q_im = {i_stage.q_im[W-2:0], n_b_im};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage.vld <= n_stage.vld;
        end
        if (i_en) begin
            r_stage.sd   <= n_stage.sd;
            r_stage.r_re <= n_stage.r_re;
            r_stage.r_im <= n_stage.r_im;
            r_stage.d    <= n_stage.d;
            r_stage.x_re <= n_stage.x_re;
            r_stage.x_im <= n_stage.x_im;
            r_stage.q_re <= n_stage.q_re;
            r_stage.q_im <= n_stage.q_im;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/cau_back.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Result selection, saturation and the output register.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cau_pkg::t_stage i_stage,
    output logic            o_en,
    cau_out_if.source       o_out
);

    localparam int W = cau_pkg::WORD_BITS;
    localparam int PW = cau_pkg::PW;

    typedef struct packed {
        logic [W-1:0] val;
        logic         ov;
    } t_sat;

    // Clamp a wide signed value into the word range.
    function automatic t_sat sat(input cau_pkg::t_wide v);
        t_sat s;
        s.ov  = 1'b0;
        s.val = v[W-1:0];
        if (v > cau_pkg::t_wide'({1'b0, {(W-1){1'b1}}})) begin
            s.ov  = 1'b1;
            s.val = {1'b0, {(W-1){1'b1}}};
        end else if (v < -cau_pkg::t_wide'({1'b1, {(W-1){1'b0}}})) begin
            s.ov  = 1'b1;
            s.val = {1'b1, {(W-1){1'b0}}};
        end
        return s;
    endfunction

    // Signed quotient from magnitude, sign and range flag.
    function automatic cau_pkg::t_wide quot(input logic [W-1:0] q, input logic neg,
                                            input logic ovf);
        cau_pkg::t_wide m;
        m = cau_pkg::t_wide'({{(PW+1-W){1'b0}}, q});
        if (ovf) begin
            m = cau_pkg::t_wide'({1'b0, {W{1'b1}}});
        end
        return neg ? -m : m;
    endfunction

    t_sat           n_sre, n_sim;
    cau_pkg::t_wide n_vre, n_vim;
    logic           r_vld;
    logic [W-1:0]   r_re, r_im;
    logic           r_dz, r_ov;

    always_comb begin
        n_vre = i_stage.sd.dre;
        n_vim = i_stage.sd.dim;
        if (i_stage.sd.act == cau_pkg::ACT_DIV) begin
            if (i_stage.sd.dz) begin
                n_vre = '0;
                n_vim = '0;
            end else begin
                n_vre = quot(i_stage.q_re, i_stage.sd.neg_re, i_stage.sd.ovf_re);
                n_vim = quot(i_stage.q_im, i_stage.sd.neg_im, i_stage.sd.ovf_im);
            end
        end
        n_sre = sat(n_vre);
        n_sim = sat(n_vim);
    end

    assign o_en = !r_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_en) begin
            r_vld <= i_stage.vld;
        end
        if (o_en) begin
            r_re <= n_sre.val;
            r_im <= n_sim.val;
            r_dz <= i_stage.sd.dz;
            r_ov <= n_sre.ov || n_sim.ov;
        end
    end

    assign o_out.valid       = r_vld;
    assign o_out.res_re      = r_re;
    assign o_out.res_im      = r_im;
    assign o_out.div_by_zero = r_dz;
    assign o_out.overflow    = r_ov;

endmodule

// ===== hdl/complex_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Pipelined complex add, subtract, multiply, divide, negate and conjugate.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// i_in     sink       action, a_re, a_im, b_re, b_im (signed Q4.28)
// o_out    source     res_re, res_im (saturated), div_by_zero, overflow
//
// One item is accepted per cycle while the output is not stalled; its result
// item passes through the front-end stages, the chain of WORD_BITS divider
// cells, one quotient bit per cell, and the output register.
// Reset clears only the valid bits of the stages.
// A stalled output holds the whole pipeline; ready follows the output stage.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);

    localparam int W = cau_pkg::WORD_BITS;

    logic            w_en;
    cau_pkg::t_stage w_ch [0:W];

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_in    (i_in),
        .o_stage (w_ch[0])
    );

    // Divider chain, most significant quotient bit first.
    for (genvar g = 0; g < W; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_ch[g]),
            .o_stage (w_ch[g+1])
        );
    end

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_ch[W]),
        .o_en    (w_en),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow the output stage");

    a_dz_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.div_by_zero) |->
            (o_out.res_re == '0 && o_out.res_im == '0 && !o_out.overflow))
        else $error("divide by zero item has nonzero result or overflow");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.res_re)
            && $stable(o_out.res_im)))
        else $error("stalled result item changed");
`endif

endmodule

// ===== sim/cau_checker.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Watches both channels. For each accepted operand item it computes the
// exact complex result, then compares every result item with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module cau_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cau_in_if    i_in,
    cau_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [cau_pkg::WORD_BITS-1:0] t_word;
    typedef logic signed [191:0]                  t_exact;

    typedef struct {
        t_word re;
        t_word im;
        logic  dz;
        logic  ov;
    } t_complex_result;

    t_complex_result expected_results[$];
    int              mismatch_count = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = expected_results.size();

    // Clamp one exact part to the word range and note any clipping.
    function automatic t_word clamp_part(input t_exact v, inout logic ov);
        t_exact hi;
        t_exact lo;
        hi = (t_exact'(1) <<< (cau_pkg::WORD_BITS - 1)) - 1;
        lo = -(t_exact'(1) <<< (cau_pkg::WORD_BITS - 1));
        if (v > hi) begin
            ov = 1'b1;
            return {1'b0, {(cau_pkg::WORD_BITS-1){1'b1}}};
        end else if (v < lo) begin
            ov = 1'b1;
            return {1'b1, {(cau_pkg::WORD_BITS-1){1'b0}}};
        end
        return v[cau_pkg::WORD_BITS-1:0];
    endfunction

    // Exact complex operation followed by saturation.
    function automatic t_complex_result compute_complex(
        input logic [2:0] act, input t_word ar, input t_word ai,
        input t_word br, input t_word bi);
        t_complex_result r;
        t_exact xr, xi, yr, yi, re, im, den;
        logic ov;
        xr = t_exact'(ar); xi = t_exact'(ai); yr = t_exact'(br); yi = t_exact'(bi);
        re = '0; im = '0; ov = 1'b0;
        r.dz = 1'b0;
        case (act)
            cau_pkg::ACT_ADD: begin
                re = xr + yr; im = xi + yi;
            end
            cau_pkg::ACT_SUB: begin
                re = xr - yr; im = xi - yi;
            end
            cau_pkg::ACT_MUL: begin
                re = (xr * yr - xi * yi) >>> cau_pkg::FRAC_BITS;
                im = (xr * yi + xi * yr) >>> cau_pkg::FRAC_BITS;
            end
            cau_pkg::ACT_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // Signed division truncates toward zero.
                    re = ((xr * yr + xi * yi) <<< cau_pkg::FRAC_BITS) / den;
                    im = ((xi * yr - xr * yi) <<< cau_pkg::FRAC_BITS) / den;
                end
            end
            cau_pkg::ACT_NEG: begin
                re = -xr; im = -xi;
            end
            cau_pkg::ACT_CONJ: begin
                re = xr; im = -xi;
            end
            default: ;
        endcase
        r.re = clamp_part(re, ov);
        r.im = clamp_part(im, ov);
        r.ov = ov;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Track accepted items on both channels.
    always @(posedge i_clk) begin
        t_complex_result want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(compute_complex(i_in.action, i_in.a_re,
                    i_in.a_im, i_in.b_re, i_in.b_im));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.res_re !== want.re)
                        report_mismatch($sformatf("res_re %h, expected %h",
                            i_out.res_re, want.re));
                    if (i_out.res_im !== want.im)
                        report_mismatch($sformatf("res_im %h, expected %h",
                            i_out.res_im, want.im));
                    if (i_out.div_by_zero !== want.dz)
                        report_mismatch($sformatf("div_by_zero %b, expected %b",
                            i_out.div_by_zero, want.dz));
                    if (i_out.overflow !== want.ov)
                        report_mismatch($sformatf("overflow %b, expected %b",
                            i_out.overflow, want.ov));
                end
            end
        end
    end

endmodule

// ===== sim/complex_arithmetic_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed corner items and then random operand items with random
// gaps and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [cau_pkg::WORD_BITS-1:0] t_word;

    localparam t_word W_MAX = {1'b0, {(cau_pkg::WORD_BITS-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(cau_pkg::WORD_BITS-1){1'b0}}};
    localparam t_word W_ONE = t_word'(1) <<< cau_pkg::FRAC_BITS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;

    cau_in_if  in_ch();
    cau_out_if out_ch();

    complex_arithmetic_unit_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cau_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #10 i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[complex_arithmetic_unit_core] ERROR");
            $finish;
        end
    end

    // Result side stalls in random bursts until the calm tail.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    end

    // Operand part: full range, moderate magnitude, or a corner code.
    function automatic t_word pick_part();
        case ($urandom_range(0, 9))
            0, 1, 2: return t_word'($urandom);
            3:       return W_MAX;
            4:       return W_MIN;
            5:       return t_word'($urandom_range(0, 2)) - 1;
            default: return t_word'($signed($urandom) >>> $urandom_range(2, 20));
        endcase
    endfunction

    // Present one item and hold it until taken, then maybe leave a gap.
    task automatic send_item(input logic [2:0] act, input t_word ar, input t_word ai,
                             input t_word br, input t_word bi);
        in_ch.action <= act;
        in_ch.a_re   <= ar;
        in_ch.a_im   <= ai;
        in_ch.b_re   <= br;
        in_ch.b_im   <= bi;
        in_ch.valid  <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [2:0] act;
        t_word      br;
        t_word      bi;
        in_ch.valid  = 1'b0;
        in_ch.action = cau_pkg::ACT_ADD;
        in_ch.a_re   = '0;
        in_ch.a_im   = '0;
        in_ch.b_re   = '0;
        in_ch.b_im   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners.
        send_item(cau_pkg::ACT_ADD, W_MAX, W_MIN, W_MAX, W_MIN);
        send_item(cau_pkg::ACT_ADD, W_MAX, W_MIN, W_MIN, W_MAX);
        send_item(cau_pkg::ACT_SUB, W_MIN, W_MAX, W_MAX, W_MIN);
        send_item(cau_pkg::ACT_SUB, W_ONE, -W_ONE, 0, 0);
        send_item(cau_pkg::ACT_MUL, W_MAX, W_MAX, W_MAX, W_MAX);
        send_item(cau_pkg::ACT_MUL, W_MIN, W_MIN, W_MIN, W_MAX);
        send_item(cau_pkg::ACT_MUL, -1, 1, -1, 1);
        send_item(cau_pkg::ACT_MUL, W_ONE, W_ONE, W_ONE, -W_ONE);
        send_item(cau_pkg::ACT_DIV, W_ONE, W_ONE, 0, 0);
        send_item(cau_pkg::ACT_DIV, W_MAX, W_MIN, 0, 0);
        send_item(cau_pkg::ACT_DIV, W_ONE, 0, W_ONE, W_ONE);
        send_item(cau_pkg::ACT_DIV, W_MAX, W_MAX, 1, 0);
        send_item(cau_pkg::ACT_DIV, W_MIN, W_MIN, W_MIN, W_MIN);
        send_item(cau_pkg::ACT_DIV, -7, 3, W_MAX, -1);
        send_item(cau_pkg::ACT_NEG, W_MIN, W_MIN, 5, 5);
        send_item(cau_pkg::ACT_NEG, W_MAX, -1, 0, 0);
        send_item(cau_pkg::ACT_CONJ, W_MIN, W_MIN, 0, 0);
        send_item(cau_pkg::ACT_CONJ, W_MAX, W_MAX, -1, -1);
        send_item(ACT_SPARE_LO, W_MAX, W_MIN, W_ONE, 3);
        send_item(ACT_SPARE_HI, -1, -1, -1, -1);

        // Random items; the tail runs with no gaps or stalls.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            act = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            br  = pick_part();
            bi  = pick_part();
            if (act == cau_pkg::ACT_DIV && $urandom_range(0, 9) == 0) begin
                br = '0;
                bi = '0;
            end
            send_item(act, pick_part(), pick_part(), br, bi);
        end
        in_ch.valid <= 1'b0;

        // Drain.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[complex_arithmetic_unit_core] OK");
        else
            $display("[complex_arithmetic_unit_core] ERROR");
        $finish;
    end

endmodule
